>>> rtl/mrf_pkg.sv
// Shared types, request codes and CRC-16 helper for the Modbus RTU request framer.
package mrf_pkg;

    localparam int FRAME_DATA_MAX = 39;
    localparam int LEN_W          = 6;
    localparam int CMD_W          = 3;

    localparam logic [CMD_W-1:0] CMD_DRIVE_IN   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LRD_IN     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_STAT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LRD_STAT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_PARAM  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_PARAM = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DIRECT     = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd7;

    localparam logic [7:0]  FN_READ_HOLD   = 8'h03;
    localparam logic [7:0]  FN_WRITE_ONE   = 8'h06;
    localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
    localparam logic [15:0] PARAM_BASE     = 16'd6144;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    // driver register addresses (low byte, high byte is zero)
    localparam logic [7:0]  REG_DRIVE_IN   = 8'h7D;
    localparam logic [7:0]  REG_LRD_IN     = 8'h1E;
    localparam logic [7:0]  REG_READ_STAT  = 8'h7F;
    localparam logic [7:0]  REG_LRD_STAT   = 8'h20;
    localparam logic [7:0]  REG_DIRECT     = 8'h58;

    typedef struct packed {
        logic load;
        logic shift;
    } mrf_ctl_t;

    typedef struct packed {
        logic init;
        logic update;
    } mrf_crc_ctl_t;

    // one byte through the reflected CRC, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

>>> rtl/modbus_rtu_motor_request_framer_top.sv
// Top level of the Modbus RTU request framer: control sequencer and output word register.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------------
//  s_       in   s_valid / s_ready  s_cmd, s_slave_id, s_command_word, s_data_no,
//                                   s_param_offset, s_value, s_drive_mode, s_steps,
//                                   s_speed, s_accel_rate, s_decel_rate, s_drive_current
//  m_       out  m_valid / m_ready  m_frame_byte, m_last_byte
//
// A request is taken only while the sequencer is idle; accepting it loads the byte shift
// register, then one frame word leaves per cycle while the sink does not stall: 8, 13 or
// 41 words. The output register holds a single word.
// Request kind 7 is taken and yields nothing.
// Reset (aresetn low at a clock edge) empties the output register and returns to idle.
// A low m_ready with a word on offer freezes the sequencer; the output word holds until taken.
module modbus_rtu_motor_request_framer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_cmd,
    input  logic [7:0]          s_slave_id,
    input  logic [15:0]         s_command_word,
    input  logic [7:0]          s_data_no,
    input  logic [5:0]          s_param_offset,
    input  logic signed [31:0]  s_value,
    input  logic signed [31:0]  s_drive_mode,
    input  logic signed [31:0]  s_steps,
    input  logic signed [31:0]  s_speed,
    input  logic signed [31:0]  s_accel_rate,
    input  logic signed [31:0]  s_decel_rate,
    input  logic signed [31:0]  s_drive_current,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_frame_byte,
    output logic                m_last_byte
);
    import mrf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DATA   = 4'b0010,
        S_CRC_LO = 4'b0100,
        S_CRC_HI = 4'b1000
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    mrf_ctl_t     sh_ctl;
    mrf_crc_ctl_t crc_ctl;
    logic [7:0]   cur_byte;
    logic         last_data;
    logic [15:0]  crc;
    logic         accept;
    logic         can_push;
    logic         push;
    logic [7:0]   push_byte;
    logic         push_last;
    logic         m_valid_reg;
    logic [7:0]   m_frame_byte_reg;
    logic         m_last_byte_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    // output slot is free or is being emptied this cycle
    assign can_push = !m_valid_reg || m_ready;

    mrf_byte_shifter u_shifter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (sh_ctl),
        .cmd           (s_cmd),
        .slave_id      (s_slave_id),
        .command_word  (s_command_word),
        .data_no       (s_data_no),
        .param_offset  (s_param_offset),
        .value         (s_value),
        .drive_mode    (s_drive_mode),
        .steps         (s_steps),
        .speed         (s_speed),
        .accel_rate    (s_accel_rate),
        .decel_rate    (s_decel_rate),
        .drive_current (s_drive_current),
        .cur_byte      (cur_byte),
        .last_data     (last_data)
    );

    mrf_crc16 u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .data    (cur_byte),
        .crc     (crc)
    );

    // sequencer: frame body words, then CRC low, then CRC high (marked last)
    always_comb begin
        state_next     = state_reg;
        push           = 1'b0;
        push_byte      = cur_byte;
        push_last      = 1'b0;
        sh_ctl.load    = accept;
        sh_ctl.shift   = 1'b0;
        crc_ctl.init   = accept;
        crc_ctl.update = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_cmd != CMD_NONE)) begin
                    state_next = S_DATA;
                end
            end
            S_DATA: begin
                if (can_push) begin
                    push           = 1'b1;
                    sh_ctl.shift   = 1'b1;
                    crc_ctl.update = 1'b1;
                    if (last_data) begin
                        state_next = S_CRC_LO;
                    end
                end
            end
            S_CRC_LO: begin
                push_byte = crc[7:0];
                if (can_push) begin
                    push       = 1'b1;
                    state_next = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                push_byte = crc[15:8];
                push_last = 1'b1;
                if (can_push) begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_frame_byte_reg <= push_byte;
            m_last_byte_reg  <= push_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_frame_byte_reg;
    assign m_last_byte  = m_last_byte_reg;

    // a real request starts the body
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd != CMD_NONE)) |=> (state_reg == S_DATA))
        else $error("request accepted but frame body not started");

    // the final body word hands over to the CRC words
    a_body_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DATA && push && last_data) |=> (state_reg == S_CRC_LO))
        else $error("CRC low word not following the frame body");

    // the CRC high word is presented as the marked last word
    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CRC_HI && push) |=> (m_valid && m_last_byte && state_reg == S_IDLE))
        else $error("closing CRC word not marked last");

    // nothing is pushed while idle
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !push)
        else $error("word pushed while idle");

endmodule

>>> rtl/mrf_byte_shifter.sv
// Frame assembly and byte-wide shift register that releases one frame byte per cycle while shift is raised.
module mrf_byte_shifter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mrf_pkg::mrf_ctl_t           ctl,
    input  logic [2:0]                  cmd,
    input  logic [7:0]                  slave_id,
    input  logic [15:0]                 command_word,
    input  logic [7:0]                  data_no,
    input  logic [5:0]                  param_offset,
    input  logic signed [31:0]          value,
    input  logic signed [31:0]          drive_mode,
    input  logic signed [31:0]          steps,
    input  logic signed [31:0]          speed,
    input  logic signed [31:0]          accel_rate,
    input  logic signed [31:0]          decel_rate,
    input  logic signed [31:0]          drive_current,
    output logic [7:0]                  cur_byte,
    output logic                        last_data
);
    import mrf_pkg::*;

    logic [7:0]       frame [FRAME_DATA_MAX];
    logic [7:0]       sr_reg [FRAME_DATA_MAX];
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] count_reg;
    logic [15:0]      addr;
    logic [31:0]      dd_words [8];

    assign addr = PARAM_BASE + {2'b00, data_no, param_offset};

    always_comb begin
        dd_words[0] = {24'h000000, data_no};
        dd_words[1] = drive_mode;
        dd_words[2] = steps;
        dd_words[3] = speed;
        dd_words[4] = accel_rate;
        dd_words[5] = decel_rate;
        dd_words[6] = drive_current;
        dd_words[7] = 32'h0000_0001;
    end

    always_comb begin
        for (int i = 0; i < FRAME_DATA_MAX; i++) begin
            frame[i] = 8'h00;
        end
        frame[0] = slave_id;
        len      = '0;
        unique case (cmd) inside
            CMD_DRIVE_IN, CMD_LRD_IN: begin
                frame[1] = FN_WRITE_ONE;
                frame[3] = (cmd == CMD_DRIVE_IN) ? REG_DRIVE_IN : REG_LRD_IN;
                frame[4] = command_word[15:8];
                frame[5] = command_word[7:0];
                len      = LEN_W'(6);
            end
            CMD_READ_STAT, CMD_LRD_STAT: begin
                frame[1] = FN_READ_HOLD;
                frame[3] = (cmd == CMD_READ_STAT) ? REG_READ_STAT : REG_LRD_STAT;
                frame[5] = 8'h01;
                len      = LEN_W'(6);
            end
            CMD_SET_PARAM: begin
                frame[1]  = FN_WRITE_MULTI;
                frame[2]  = addr[15:8];
                frame[3]  = addr[7:0];
                frame[5]  = 8'h02;
                frame[6]  = 8'h04;
                frame[7]  = value[31:24];
                frame[8]  = value[23:16];
                frame[9]  = value[15:8];
                frame[10] = value[7:0];
                len       = LEN_W'(11);
            end
            CMD_READ_PARAM: begin
                frame[1] = FN_READ_HOLD;
                frame[2] = addr[15:8];
                frame[3] = addr[7:0];
                frame[5] = 8'h02;
                len      = LEN_W'(6);
            end
            CMD_DIRECT: begin
                frame[1] = FN_WRITE_MULTI;
                frame[3] = REG_DIRECT;
                frame[5] = 8'h10;
                frame[6] = 8'h20;
                for (int k = 0; k < 8; k++) begin
                    for (int b = 0; b < 4; b++) begin
                        frame[7 + 4*k + b] = dd_words[k][31 - 8*b -: 8];
                    end
                end
                len = LEN_W'(FRAME_DATA_MAX);
            end
            default: begin
                len = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.load) begin
            count_reg <= len;
        end else if (ctl.shift) begin
            count_reg <= count_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            sr_reg <= frame;
        end else if (ctl.shift) begin
            for (int i = 0; i < FRAME_DATA_MAX - 1; i++) begin
                sr_reg[i] <= sr_reg[i+1];
            end
            sr_reg[FRAME_DATA_MAX-1] <= 8'h00;
        end
    end

    assign cur_byte  = sr_reg[0];
    assign last_data = (count_reg == LEN_W'(1));

endmodule

>>> rtl/mrf_crc16.sv
// Running Modbus CRC-16, one byte folded in per cycle while update is raised.
module mrf_crc16 (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mrf_pkg::mrf_crc_ctl_t   ctl,
    input  logic [7:0]              data,
    output logic [15:0]             crc
);
    import mrf_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (ctl.init) begin
            crc_next = CRC_INIT;
        end else if (ctl.update) begin
            crc_next = crc16_byte(crc_reg, data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU request framer: random traffic, frame prediction.
module testbench;
    import mrf_pkg::*;

    // Fixed frame contents used by the predictor
    localparam logic [7:0]  PARAM_WORDS    = 8'h02;
    localparam logic [7:0]  PARAM_BYTES    = 8'h04;
    localparam logic [7:0]  DIRECT_WORDS   = 8'h10;
    localparam logic [7:0]  DIRECT_BYTES   = 8'h20;
    localparam logic [31:0] DIRECT_TRIGGER = 32'd1;

    localparam int RANDOM_REQUESTS = 415;   // requests that yield a frame
    localparam int TAIL_CYCLES     = 60;    // one full direct-drive frame and then some
    localparam int PRINT_CAP       = 100;

    typedef struct {
        logic [2:0]         cmd;
        logic [7:0]         slave_id;
        logic [15:0]        command_word;
        logic [7:0]         data_no;
        logic [5:0]         param_offset;
        logic signed [31:0] value;
        logic signed [31:0] drive_mode;
        logic signed [31:0] steps;
        logic signed [31:0] speed;
        logic signed [31:0] accel_rate;
        logic signed [31:0] decel_rate;
        logic signed [31:0] drive_current;
    } request_t;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_beat_t;

    // DUT ports
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic [7:0]         s_slave_id;
    logic [15:0]        s_command_word;
    logic [7:0]         s_data_no;
    logic [5:0]         s_param_offset;
    logic signed [31:0] s_value;
    logic signed [31:0] s_drive_mode;
    logic signed [31:0] s_steps;
    logic signed [31:0] s_speed;
    logic signed [31:0] s_accel_rate;
    logic signed [31:0] s_decel_rate;
    logic signed [31:0] s_drive_current;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_frame_byte;
    logic               m_last_byte;

    // Stimulus and scoreboard state
    request_t    requests_pending[$];   // words still to be offered on s_
    frame_beat_t frame_bytes_due[$];    // predicted frame bytes, oldest first
    int unsigned mismatch_count = 0;

    // Handshake flags, set at the rising edge and read by the drivers at the falling edge
    bit          req_taken  = 0;
    bit          byte_taken = 0;

    // Driver state
    bit          req_held  = 0;
    int unsigned req_gap   = 0;
    int unsigned req_calm  = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_calm = 0;
    request_t    next_req;

    modbus_rtu_motor_request_framer_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_slave_id      (s_slave_id),
        .s_command_word  (s_command_word),
        .s_data_no       (s_data_no),
        .s_param_offset  (s_param_offset),
        .s_value         (s_value),
        .s_drive_mode    (s_drive_mode),
        .s_steps         (s_steps),
        .s_speed         (s_speed),
        .s_accel_rate    (s_accel_rate),
        .s_decel_rate    (s_decel_rate),
        .s_drive_current (s_drive_current),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_last_byte     (m_last_byte)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Idle cycles before the next word, drawn at random, with occasional runs of back-to-back words
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 9);
    endfunction

    // 32-bit field: mostly uniform, now and then one of the corner patterns
    function automatic logic [31:0] rand_word32();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Every field random, including those the kind ignores
    function automatic request_t random_request(input logic [2:0] kind);
        request_t rq;
        rq.cmd           = kind;
        rq.slave_id      = 8'($urandom_range(0, 255));
        rq.command_word  = 16'($urandom_range(0, 65535));
        rq.data_no       = 8'($urandom_range(0, 255));
        rq.param_offset  = 6'($urandom_range(0, 63));
        rq.value         = rand_word32();
        rq.drive_mode    = rand_word32();
        rq.steps         = rand_word32();
        rq.speed         = rand_word32();
        rq.accel_rate    = rand_word32();
        rq.decel_rate    = rand_word32();
        rq.drive_current = rand_word32();
        return rq;
    endfunction

    // Reflected CRC-16, one byte in, LSB first
    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc,
                                                    input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        repeat (8) begin
            acc = {1'b0, acc[15:1]} ^ (acc[0] ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    // Build the whole frame a request should produce and queue its bytes
    task automatic build_request_frame(input request_t rq);
        logic [7:0]   fr [0:40];
        logic [255:0] blk;
        logic [15:0]  addr;
        logic [15:0]  crc;
        int unsigned  len;
        frame_beat_t  beat;
        addr = PARAM_BASE + {2'b00, rq.data_no, 6'b000000} + {10'd0, rq.param_offset};
        // data number padded to a word, six drive words, then the trigger word
        blk  = {24'd0, rq.data_no, rq.drive_mode, rq.steps, rq.speed, rq.accel_rate,
                rq.decel_rate, rq.drive_current, DIRECT_TRIGGER};
        for (int k = 0; k < 41; k++) fr[k] = 8'h00;
        fr[0] = rq.slave_id;
        len   = 0;
        case (rq.cmd) inside
            CMD_DRIVE_IN, CMD_LRD_IN: begin
                fr[1] = FN_WRITE_ONE;
                fr[3] = (rq.cmd == CMD_DRIVE_IN) ? REG_DRIVE_IN : REG_LRD_IN;
                fr[4] = rq.command_word[15:8];
                fr[5] = rq.command_word[7:0];
                len   = 6;
            end
            CMD_READ_STAT, CMD_LRD_STAT: begin
                fr[1] = FN_READ_HOLD;
                fr[3] = (rq.cmd == CMD_READ_STAT) ? REG_READ_STAT : REG_LRD_STAT;
                fr[5] = 8'h01;
                len   = 6;
            end
            CMD_SET_PARAM: begin
                fr[1] = FN_WRITE_MULTI;
                fr[2] = addr[15:8];
                fr[3] = addr[7:0];
                fr[5] = PARAM_WORDS;
                fr[6] = PARAM_BYTES;
                for (int k = 0; k < 4; k++) fr[7 + k] = rq.value[31 - 8 * k -: 8];
                len   = 11;
            end
            CMD_READ_PARAM: begin
                fr[1] = FN_READ_HOLD;
                fr[2] = addr[15:8];
                fr[3] = addr[7:0];
                fr[5] = PARAM_WORDS;
                len   = 6;
            end
            CMD_DIRECT: begin
                fr[1] = FN_WRITE_MULTI;
                fr[3] = REG_DIRECT;
                fr[5] = DIRECT_WORDS;
                fr[6] = DIRECT_BYTES;
                for (int k = 0; k < 32; k++) fr[7 + k] = blk[255 - 8 * k -: 8];
                len   = 39;
            end
            default: len = 0;   // unused kind: taken, nothing sent
        endcase
        if (len != 0) begin
            crc = CRC_INIT;
            for (int k = 0; k < len; k++) crc = modbus_crc_next(crc, fr[k]);
            fr[len]     = crc[7:0];
            fr[len + 1] = crc[15:8];
            for (int k = 0; k < len + 2; k++) begin
                beat.frame_byte = fr[k];
                beat.last_byte  = (k == len + 1);
                frame_bytes_due.push_back(beat);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Monitor: at each rising edge, predict from every accepted request word
    // (before checking, so a same-edge byte still meets its expectation) and
    // check every accepted frame word against the oldest prediction.
    always @(posedge aclk) begin
        frame_beat_t want;
        request_t    seen;
        req_taken  = 1'b0;
        byte_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                req_taken          = 1'b1;
                seen.cmd           = s_cmd;
                seen.slave_id      = s_slave_id;
                seen.command_word  = s_command_word;
                seen.data_no       = s_data_no;
                seen.param_offset  = s_param_offset;
                seen.value         = s_value;
                seen.drive_mode    = s_drive_mode;
                seen.steps         = s_steps;
                seen.speed         = s_speed;
                seen.accel_rate    = s_accel_rate;
                seen.decel_rate    = s_decel_rate;
                seen.drive_current = s_drive_current;
                build_request_frame(seen);
            end
            if (m_valid && m_ready) begin
                byte_taken = 1'b1;
                if (frame_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame word %02h last=%0b",
                                              m_frame_byte, m_last_byte));
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_frame_byte !== want.frame_byte) begin
                        report_mismatch($sformatf("frame_byte %02h, predicted %02h",
                                                  m_frame_byte, want.frame_byte));
                    end
                    if (m_last_byte !== want.last_byte) begin
                        report_mismatch($sformatf("last_byte %0b, predicted %0b (byte %02h)",
                                                  m_last_byte, want.last_byte, want.frame_byte));
                    end
                end
            end
        end
    end

    // Request driver: on the falling edge, drop a word once taken, sit out its
    // drawn gap, then present the next pending word and hold it until taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (req_taken) begin
                req_held = 1'b0;
                req_gap  = draw_wait(req_calm);
            end
            if (!req_held) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (requests_pending.size() > 0) begin
                    next_req        = requests_pending.pop_front();
                    req_held        = 1'b1;
                    s_cmd           <= next_req.cmd;
                    s_slave_id      <= next_req.slave_id;
                    s_command_word  <= next_req.command_word;
                    s_data_no       <= next_req.data_no;
                    s_param_offset  <= next_req.param_offset;
                    s_value         <= next_req.value;
                    s_drive_mode    <= next_req.drive_mode;
                    s_steps         <= next_req.steps;
                    s_speed         <= next_req.speed;
                    s_accel_rate    <= next_req.accel_rate;
                    s_decel_rate    <= next_req.decel_rate;
                    s_drive_current <= next_req.drive_current;
                end
            end
            s_valid <= req_held;
        end
    end

    // Frame sink: after each taken word, stall for the drawn number of cycles
    // in which a word is on offer, so the stall lands mid-frame as well.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (byte_taken) begin
                sink_wait = draw_wait(sink_calm);
            end
            if (sink_wait > 0) begin
                if (m_valid) begin
                    sink_wait--;
                end
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        request_t    rq;
        int unsigned framed;
        logic [2:0]  kind;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_cmd           = CMD_NONE;
        s_slave_id      = 8'h00;
        s_command_word  = 16'h0000;
        s_data_no       = 8'h00;
        s_param_offset  = 6'd0;
        s_value         = 32'sd0;
        s_drive_mode    = 32'sd0;
        s_steps         = 32'sd0;
        s_speed         = 32'sd0;
        s_accel_rate    = 32'sd0;
        s_decel_rate    = 32'sd0;
        s_drive_current = 32'sd0;
        m_ready         = 1'b0;

        // Directed: field extremes and every kind, including the unused one
        rq = random_request(CMD_DRIVE_IN);
        rq.slave_id = 8'h00; rq.command_word = 16'h0000;
        requests_pending.push_back(rq);
        rq = random_request(CMD_DRIVE_IN);
        rq.slave_id = 8'hFF; rq.command_word = 16'hFFFF;
        requests_pending.push_back(rq);
        rq = random_request(CMD_LRD_IN);
        rq.slave_id = 8'h01; rq.command_word = 16'h8001;
        requests_pending.push_back(rq);
        rq = random_request(CMD_LRD_IN);
        rq.slave_id = 8'hFE; rq.command_word = 16'h7FFE;
        requests_pending.push_back(rq);
        rq = random_request(CMD_READ_STAT);
        rq.slave_id = 8'hFF;
        requests_pending.push_back(rq);
        rq = random_request(CMD_LRD_STAT);
        rq.slave_id = 8'h00;
        requests_pending.push_back(rq);
        // parameter address at both ends of its range
        rq = random_request(CMD_SET_PARAM);
        rq.data_no = 8'd0; rq.param_offset = 6'd0; rq.value = 32'h8000_0000;
        requests_pending.push_back(rq);
        rq = random_request(CMD_SET_PARAM);
        rq.data_no = 8'd255; rq.param_offset = 6'd63; rq.value = 32'h7FFF_FFFF;
        requests_pending.push_back(rq);
        rq = random_request(CMD_SET_PARAM);
        rq.value = 32'hFFFF_FFFF; rq.slave_id = 8'h00;
        requests_pending.push_back(rq);
        rq = random_request(CMD_READ_PARAM);
        rq.data_no = 8'd0; rq.param_offset = 6'd0;
        requests_pending.push_back(rq);
        rq = random_request(CMD_READ_PARAM);
        rq.data_no = 8'd255; rq.param_offset = 6'd63;
        requests_pending.push_back(rq);
        // direct drive: all zero, all ones, then alternating signs
        rq = random_request(CMD_DIRECT);
        rq.data_no = 8'd0; rq.drive_mode = 0; rq.steps = 0; rq.speed = 0;
        rq.accel_rate = 0; rq.decel_rate = 0; rq.drive_current = 0;
        requests_pending.push_back(rq);
        rq = random_request(CMD_DIRECT);
        rq.data_no = 8'd255; rq.drive_mode = -1; rq.steps = -1; rq.speed = -1;
        rq.accel_rate = -1; rq.decel_rate = -1; rq.drive_current = -1;
        requests_pending.push_back(rq);
        rq = random_request(CMD_DIRECT);
        rq.drive_mode = 32'h8000_0000; rq.steps = 32'h7FFF_FFFF;
        rq.speed = 32'h8000_0000; rq.accel_rate = 32'h7FFF_FFFF;
        rq.decel_rate = 32'h8000_0000; rq.drive_current = 32'h7FFF_FFFF;
        requests_pending.push_back(rq);
        // unused kind, alone and between frames
        requests_pending.push_back(random_request(CMD_NONE));
        requests_pending.push_back(random_request(CMD_NONE));
        requests_pending.push_back(random_request(CMD_READ_STAT));
        requests_pending.push_back(random_request(CMD_NONE));
        requests_pending.push_back(random_request(CMD_DIRECT));

        // Random: all kinds about equally, the unused one now and then
        framed = 0;
        while (framed < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 15) == 0) begin
                kind = CMD_NONE;
            end else begin
                kind = 3'($urandom_range(0, 6));
                framed++;
            end
            requests_pending.push_back(random_request(kind));
        end

        // Synchronous reset, released on a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: nothing left to send, nothing on offer, no frame byte outstanding
        do begin
            @(posedge aclk);
        end while (requests_pending.size() != 0 || req_held || frame_bytes_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: the slowest legal run is well under a quarter of this
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/mrf_pkg.sv
rtl/mrf_byte_shifter.sv
rtl/mrf_crc16.sv
rtl/modbus_rtu_motor_request_framer_top.sv
tb/sv/testbench.sv
